// ----- rtl/baro_sensor_compensation_assert.svh -----
// Assertion macros for the barometric compensation block.
// No dependencies; included by the top level, which supplies clk and rst.
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

// Concurrent check on the block clock, muted while reset is asserted.
`define BARO_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that also covers the reset cycles.
`define BARO_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/baro_pkg.sv -----
// Shared types, constants and helpers for the barometric compensation block.
// No dependencies; used by baro_div and baro_sensor_compensation.
package baro_pkg;

  localparam int DivBits = 32;

  typedef enum logic [2:0] {
    REG_OSS     = 3'd0,
    REG_AC1_AC2 = 3'd1,
    REG_AC3_AC4 = 3'd2,
    REG_AC5_AC6 = 3'd3,
    REG_B1_B2   = 3'd4,
    REG_MC_MD   = 3'd5
  } reg_idx_t;

  localparam logic [31:0] C_B6_OFFSET = 32'd4000;
  localparam logic [31:0] C_P_SQ_COEF = 32'd3038;
  localparam logic [31:0] C_P_LIN_COEF = 32'd0 - 32'd7357;
  localparam logic [31:0] C_P_OFFSET = 32'd3791;
  localparam logic [31:0] C_B7_SCALE = 32'd50000;
  localparam logic [31:0] C_B4_BIAS = 32'd32768;
  localparam logic [31:0] C_T_ROUND = 32'd8;
  localparam logic [31:0] C_QUARTER_ROUND = 32'd2;

  typedef struct packed {
    logic [15:0] temp_raw;
    logic [23:0] press_raw_bytes;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temp_tenths;
    logic signed [31:0] press_pascal;
    logic               div_error;
  } result_t;

  // Context riding alongside a divider request.
  // word holds x1 through the temperature divider and t through the pressure one.
  typedef struct packed {
    logic        err;
    logic        flag;
    logic [23:0] up;
    logic [31:0] word;
  } side_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ----- rtl/baro_div.sv -----
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Depends on baro_pkg (DivBits, side_t).
module baro_div import baro_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] num,
  input  logic [31:0] dvs,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] quo,
  output side_t       out_side
);

  logic [DivBits-1:0] vld;
  logic [31:0]        rem_q [DivBits];
  logic [31:0]        num_q [DivBits];
  logic [31:0]        dvs_q [DivBits];
  logic [31:0]        quo_q [DivBits];
  side_t              side_q [DivBits];

  for (genvar k = 0; k < DivBits; k++) begin : g_stage
    logic        v_in;
    logic [31:0] r_in, n_in, d_in, q_in;
    side_t       s_in;
    logic [32:0] trial;
    logic [33:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign n_in = num;
      assign d_in = dvs;
      assign q_in = '0;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = vld[k-1];
      assign r_in = rem_q[k-1];
      assign n_in = num_q[k-1];
      assign d_in = dvs_q[k-1];
      assign q_in = quo_q[k-1];
      assign s_in = side_q[k-1];
    end

    assign trial = {r_in, n_in[31]};
    assign diff  = {1'b0, trial} - {2'b00, d_in};
    assign ge    = !diff[33];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[31:0] : trial[31:0];
        num_q[k]  <= {n_in[30:0], 1'b0};
        dvs_q[k]  <= d_in;
        quo_q[k]  <= {q_in[30:0], ge};
        side_q[k] <= s_in;
      end
    end
  end

  assign out_valid = vld[DivBits-1];
  assign quo       = quo_q[DivBits-1];
  assign out_side  = side_q[DivBits-1];

endmodule

// ----- rtl/baro_sensor_compensation.sv -----
// Top level of the barometric pressure/temperature compensation pipeline.
// Depends on baro_pkg, baro_div and baro_sensor_compensation_assert.svh.

// Accepts one request (raw temperature word plus three raw pressure bytes) per
// clock while the output is not stalled and returns one result per request,
// in order. The pipeline is made of the two 32-stage bit-per-cycle dividers
// (temperature and pressure) plus 12 arithmetic stages, each holding up to
// three multiplies. A stall while a result is held freezes the whole pipeline;
// no request is lost or duplicated. Calibration and oversampling registers are
// written through the cfg port (always ready) and must only be changed while
// the pipeline is empty. A zero divisor in either divide sets div_error and
// forces both outputs to zero.
module baro_sensor_compensation import baro_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // sample requests
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  // results
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  `include "baro_sensor_compensation_assert.svh"

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]  oss;
  logic [31:0] cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      oss         <= '0;
      cal_ac1_ac2 <= '0;
      cal_ac3_ac4 <= '0;
      cal_ac5_ac6 <= '0;
      cal_b1_b2   <= '0;
      cal_mc_md   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OSS:     oss         <= cfg_data[1:0];
        REG_AC1_AC2: cal_ac1_ac2 <= cfg_data;
        REG_AC3_AC4: cal_ac3_ac4 <= cfg_data;
        REG_AC5_AC6: cal_ac5_ac6 <= cfg_data;
        REG_B1_B2:   cal_b1_b2   <= cfg_data;
        REG_MC_MD:   cal_mc_md   <= cfg_data;
        default: ;  // out-of-range index: write dropped
      endcase
    end
  end

  // Coefficients, sign-extended per datasheet (ac4..ac6 unsigned).
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(cal_ac1_ac2[31:16]);
  assign ac2 = sx16(cal_ac1_ac2[15:0]);
  assign ac3 = sx16(cal_ac3_ac4[31:16]);
  assign ac4 = {16'h0, cal_ac3_ac4[15:0]};
  assign ac5 = {16'h0, cal_ac5_ac6[31:16]};
  assign ac6 = {16'h0, cal_ac5_ac6[15:0]};
  assign b1  = sx16(cal_b1_b2[31:16]);
  assign b2  = sx16(cal_b1_b2[15:0]);
  assign mc  = sx16(cal_mc_md[31:16]);
  assign md  = sx16(cal_mc_md[15:0]);

  // Whole pipeline advances together unless the output register is held.
  logic en;
  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  // ---------------------------------------------------------------------------
  // S1: UT product, UP alignment
  // ---------------------------------------------------------------------------
  logic        v1;
  logic [31:0] s1_m;
  logic [23:0] s1_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m  <= ({16'h0, sample.temp_raw} - ac6) * ac5;
      s1_up <= 24'(sample.press_raw_bytes >> (4'd8 - {2'b00, oss}));
    end
  end

  // ---------------------------------------------------------------------------
  // S2: temperature divide setup (signed -> magnitudes)
  // ---------------------------------------------------------------------------
  logic        v2;
  logic [31:0] s2_num, s2_dvs;
  side_t       s2_side;
  logic [31:0] x1_t, den_t, mc_sh;

  assign x1_t  = asr32(s1_m, 5'd15);
  assign den_t = x1_t + md;
  assign mc_sh = mc << 11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_num       <= mc_sh[31] ? 32'd0 - mc_sh : mc_sh;
      s2_dvs       <= den_t[31] ? 32'd0 - den_t : den_t;
      s2_side.err  <= (den_t == 32'd0);
      s2_side.flag <= mc_sh[31] ^ den_t[31];  // quotient sign
      s2_side.up   <= s1_up;
      s2_side.word <= x1_t;
    end
  end

  logic        dt_valid;
  logic [31:0] dt_quo;
  side_t       dt_side;

  baro_div u_div_temp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .num      (s2_num),
    .dvs      (s2_dvs),
    .in_side  (s2_side),
    .out_valid(dt_valid),
    .quo      (dt_quo),
    .out_side (dt_side)
  );

  // ---------------------------------------------------------------------------
  // D1: B5, temperature, B6
  // ---------------------------------------------------------------------------
  logic        v3;
  logic [31:0] d1_t, d1_b6;
  logic [23:0] d1_up;
  logic        d1_err;
  logic [31:0] x2_t, b5;

  assign x2_t = dt_side.flag ? 32'd0 - dt_quo : dt_quo;
  assign b5   = dt_side.word + x2_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= dt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_t   <= asr32(b5 + C_T_ROUND, 5'd4);
      d1_b6  <= b5 - C_B6_OFFSET;
      d1_up  <= dt_side.up;
      d1_err <= dt_side.err;
    end
  end

  // ---------------------------------------------------------------------------
  // P1: B6 products
  // ---------------------------------------------------------------------------
  logic        v4;
  logic [31:0] p1_sqm, p1_m2, p1_m3, p1_t;
  logic [23:0] p1_up;
  logic        p1_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_sqm <= d1_b6 * d1_b6;
      p1_m2  <= ac2 * d1_b6;
      p1_m3  <= ac3 * d1_b6;
      p1_t   <= d1_t;
      p1_up  <= d1_up;
      p1_err <= d1_err;
    end
  end

  // ---------------------------------------------------------------------------
  // P2: scale products
  // ---------------------------------------------------------------------------
  logic        v5;
  logic [31:0] p2_sq, p2_xa, p2_xc, p2_t;
  logic [23:0] p2_up;
  logic        p2_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_sq  <= asr32(p1_sqm, 5'd12);
      p2_xa  <= asr32(p1_m2, 5'd11);
      p2_xc  <= asr32(p1_m3, 5'd13);
      p2_t   <= p1_t;
      p2_up  <= p1_up;
      p2_err <= p1_err;
    end
  end

  // ---------------------------------------------------------------------------
  // P3: b1/b2 against B6 squared
  // ---------------------------------------------------------------------------
  logic        v6;
  logic [31:0] p3_mb2, p3_mb1, p3_xa, p3_xc, p3_t;
  logic [23:0] p3_up;
  logic        p3_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_mb2 <= b2 * p2_sq;
      p3_mb1 <= b1 * p2_sq;
      p3_xa  <= p2_xa;
      p3_xc  <= p2_xc;
      p3_t   <= p2_t;
      p3_up  <= p2_up;
      p3_err <= p2_err;
    end
  end

  // ---------------------------------------------------------------------------
  // P4: B3 and the B4 multiplicand
  // ---------------------------------------------------------------------------
  logic        v7;
  logic [31:0] p4_b3, p4_x3s, p4_t;
  logic [23:0] p4_up;
  logic        p4_err;
  logic [31:0] x3_a, b3_base, x3_b;

  assign x3_a    = asr32(p3_mb2, 5'd11) + p3_xa;
  assign b3_base = ((ac1 << 2) + x3_a) << oss;
  assign x3_b    = asr32(p3_xc + asr32(p3_mb1, 5'd16) + C_QUARTER_ROUND, 5'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_b3  <= asr32(b3_base + C_QUARTER_ROUND, 5'd2);
      p4_x3s <= x3_b + C_B4_BIAS;
      p4_t   <= p3_t;
      p4_up  <= p3_up;
      p4_err <= p3_err;
    end
  end

  // ---------------------------------------------------------------------------
  // P5: B4 product, UP - B3
  // ---------------------------------------------------------------------------
  logic        v8;
  logic [31:0] p5_b4m, p5_ud, p5_t;
  logic        p5_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5_b4m <= ac4 * p4_x3s;
      p5_ud  <= {8'h00, p4_up} - p4_b3;
      p5_t   <= p4_t;
      p5_err <= p4_err;
    end
  end

  // ---------------------------------------------------------------------------
  // P6: B4, B7
  // ---------------------------------------------------------------------------
  logic        v9;
  logic [31:0] p6_b4, p6_b7, p6_t;
  logic        p6_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p6_b4  <= p5_b4m >> 15;
      p6_b7  <= p5_ud * (C_B7_SCALE >> oss);
      p6_t   <= p5_t;
      p6_err <= p5_err;
    end
  end

  // Pressure divide: B7 below 2^31 is doubled before dividing, else after.
  side_t       pd_in_side;
  logic [31:0] pd_num;
  logic        dp_valid;
  logic [31:0] dp_quo;
  side_t       dp_side;

  assign pd_num          = p6_b7[31] ? p6_b7 : {p6_b7[30:0], 1'b0};
  assign pd_in_side.err  = p6_err || (p6_b4 == 32'd0);
  assign pd_in_side.flag = p6_b7[31];
  assign pd_in_side.up   = '0;
  assign pd_in_side.word = p6_t;

  baro_div u_div_press (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v9),
    .num      (pd_num),
    .dvs      (p6_b4),
    .in_side  (pd_in_side),
    .out_valid(dp_valid),
    .quo      (dp_quo),
    .out_side (dp_side)
  );

  // ---------------------------------------------------------------------------
  // Q0: raw pressure, correction products
  // ---------------------------------------------------------------------------
  logic        v10;
  logic [31:0] q0_p, q0_sqm, q0_lin, q0_t;
  logic        q0_err;
  logic [31:0] p_raw, p_hi;

  assign p_raw = dp_side.flag ? {dp_quo[30:0], 1'b0} : dp_quo;
  assign p_hi  = asr32(p_raw, 5'd8);

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= dp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q0_p   <= p_raw;
      q0_sqm <= p_hi * p_hi;
      q0_lin <= C_P_LIN_COEF * p_raw;
      q0_t   <= dp_side.word;
      q0_err <= dp_side.err;
    end
  end

  // ---------------------------------------------------------------------------
  // Q1: quadratic term
  // ---------------------------------------------------------------------------
  logic        v11;
  logic [31:0] q1_p, q1_mm, q1_x2, q1_t;
  logic        q1_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (en) begin
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_p   <= q0_p;
      q1_mm  <= q0_sqm * C_P_SQ_COEF;
      q1_x2  <= asr32(q0_lin, 5'd16);
      q1_t   <= q0_t;
      q1_err <= q0_err;
    end
  end

  // ---------------------------------------------------------------------------
  // Q2: output register, zero-divisor masking
  // ---------------------------------------------------------------------------
  logic [31:0] p_final;
  assign p_final = q1_p + asr32(asr32(q1_mm, 5'd16) + q1_x2 + C_P_OFFSET, 5'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.temp_tenths  <= q1_err ? '0 : q1_t;
      result.press_pascal <= q1_err ? '0 : p_final;
      result.div_error    <= q1_err;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `BARO_CHECK(a_stall_needs_result, sample_stall |-> result_valid, "input stalled with no result held")
  `BARO_CHECK(a_err_zeroes, (result_valid && result.div_error) |-> (result.temp_tenths == 0 && result.press_pascal == 0), "div_error result not zeroed")
  `BARO_CHECK(a_held_result_stable, (result_valid && result_stall) |=> (result_valid && $stable(result)), "held result changed")
  `BARO_CHECK_ALWAYS(a_cfg_ready, cfg_ready, "config port not ready")

endmodule
